// File: rtl/feistel_sbox_block_cipher_macros.svh
// assertion macros shared by the cipher rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef FEISTEL_SBOX_BLOCK_CIPHER_MACROS_SVH
`define FEISTEL_SBOX_BLOCK_CIPHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsbc assertion failed");

// next-cycle implication
`define FSBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsbc assertion failed");

`else

`define FSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/fsbc_pkg.sv
// shared types, constants and s-box functions for the feistel cipher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsbc_pkg;

	localparam int ROUND_COUNT = 16;
	localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int ROT_W = 5;
	localparam int HALF_W = 32;
	localparam int BLOCK_W = 2 * HALF_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUND_COUNT - 1);

	localparam logic [7:0] SBOX_FWD [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] SBOX_INV [0:255] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP,
		ST_PRIME,
		ST_ENC,
		ST_DEC,
		ST_OUT
	} fsbc_state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] step_idx;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} fsbc_key_ctrl_t;

	function automatic logic [HALF_W-1:0] sub_fwd(input logic [HALF_W-1:0] x);
		return {SBOX_FWD[x[31:24]], SBOX_FWD[x[23:16]], SBOX_FWD[x[15:8]], SBOX_FWD[x[7:0]]};
	endfunction

	function automatic logic [HALF_W-1:0] sub_inv(input logic [HALF_W-1:0] x);
		return {SBOX_INV[x[31:24]], SBOX_INV[x[23:16]], SBOX_INV[x[15:8]], SBOX_INV[x[7:0]]};
	endfunction

	function automatic logic [HALF_W-1:0] rotl32(input logic [HALF_W-1:0] x,
			input logic [ROT_W-1:0] n);
		logic [BLOCK_W-1:0] w;
		w = {x, x} << n;
		return w[BLOCK_W-1:HALF_W];
	endfunction

endpackage

`default_nettype wire

// File: rtl/fsbc_key_sched.sv
// key register, one-step key expansion unit and round key store
// depends on fsbc_pkg and feistel_sbox_block_cipher_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "feistel_sbox_block_cipher_macros.svh"

module fsbc_key_sched (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [fsbc_pkg::HALF_W-1:0]  cfg_wdata,
	input  wire fsbc_pkg::fsbc_key_ctrl_t     ctrl,
	output logic      [fsbc_pkg::HALF_W-1:0]  step_key,
	output logic      [fsbc_pkg::HALF_W-1:0]  rd_key,
	output logic                              keys_valid
);
	import fsbc_pkg::*;

	logic [HALF_W-1:0] cipher_key_q;
	logic [HALF_W-1:0] key_q;
	logic [HALF_W-1:0] rd_key_q;
	logic              keys_valid_q;
	logic [HALF_W-1:0] key_store [0:ROUND_COUNT-1];
	logic [ROT_W-1:0]  rot_amt;

	// round r rotates by r, with r counted from one
	assign rot_amt  = ROT_W'(ctrl.step_idx) + ROT_W'(1);
	assign step_key = rotl32(sub_fwd(key_q), rot_amt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= '0;
			keys_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cipher_key_q <= cfg_wdata;
			end
			if (cfg_wen) begin
				keys_valid_q <= 1'b0;
			end else if (ctrl.step && ctrl.step_idx == LAST_IDX) begin
				keys_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= cipher_key_q;
		end else if (ctrl.step) begin
			key_q <= step_key;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			key_store[ctrl.step_idx] <= step_key;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_key_q <= key_store[ctrl.rd_idx];
		end
	end

	assign rd_key     = rd_key_q;
	assign keys_valid = keys_valid_q;

	`FSBC_ASSERT_NXT(a_cfg_drops_keys, clk, arst_n, cfg_wen, !keys_valid_q)
	`FSBC_ASSERT_NXT(a_last_step_sets_valid, clk, arst_n,
		ctrl.step && ctrl.step_idx == LAST_IDX && !cfg_wen, keys_valid_q)
	`FSBC_ASSERT_IMP(a_no_read_while_step, clk, arst_n, ctrl.step, !ctrl.rd_en)

endmodule

`default_nettype wire

// File: rtl/feistel_sbox_block_cipher.sv
// 64-bit feistel cipher, 16 rounds, one shared round unit under a sequencer
// depends on fsbc_pkg, fsbc_key_sched and feistel_sbox_block_cipher_macros.svh
//
// usage:
//   s_tdata carries the 64-bit block (left half in bits 63:32), s_tuser selects
//   encrypt (0) or decrypt (1); one item in gives one item out on m_tdata.
//   cfg_wen/cfg_wdata load the 32-bit key; write it only while the block is idle.
// timing:
//   one round per cycle through a single round unit. an encrypt item runs its
//   rounds after the accept, with round keys derived on the fly and saved in a
//   16-entry key store. decrypt reads the store in reverse when it already
//   holds keys of the current key, otherwise it first runs 16 expansion steps
//   and a read prime. a key write invalidates the store.
//   s_tready is high only while the sequencer is idle.
// reset:
//   arst_n clears the sequencer, the output valid, the key and the store flag.
// stalls:
//   a finished result sits in the output register; if it has not been taken
//   when the next one finishes, the sequencer holds that one until it is.
`timescale 1ns / 1ps
`default_nettype none
`include "feistel_sbox_block_cipher_macros.svh"

module feistel_sbox_block_cipher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [fsbc_pkg::HALF_W-1:0]   cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [fsbc_pkg::BLOCK_W-1:0]  s_tdata,  // data_block
	input  wire logic                          s_tuser,  // func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [fsbc_pkg::BLOCK_W-1:0]  m_tdata   // result_block
);
	import fsbc_pkg::*;

	fsbc_state_t      state_q;
	fsbc_state_t      state_nxt;
	fsbc_key_ctrl_t   key_ctrl;
	logic [IDX_W-1:0] cnt_q;
	logic             dec_q;
	logic [HALF_W-1:0] left_q;
	logic [HALF_W-1:0] right_q;
	logic [HALF_W-1:0] left_nxt;
	logic [HALF_W-1:0] right_nxt;
	logic [HALF_W-1:0] step_key;
	logic [HALF_W-1:0] rd_key;
	logic [HALF_W-1:0] round_key;
	logic [HALF_W-1:0] f_out;
	logic [HALF_W-1:0] mixed;
	logic              keys_valid;
	logic              accept;
	logic              out_free;
	logic              cnt_last;
	logic              cnt_step;
	logic              round_en;
	logic              out_load;
	logic              m_tvalid_q;
	logic [BLOCK_W-1:0] m_tdata_q;

	fsbc_key_sched u_key_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.ctrl       (key_ctrl),
		.step_key   (step_key),
		.rd_key     (rd_key),
		.keys_valid (keys_valid)
	);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_last = (cnt_q == LAST_IDX);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q) inside
			ST_IDLE: begin
				if (accept) begin
					if (!s_tuser) begin
						state_nxt = ST_ENC;
					end else if (keys_valid) begin
						state_nxt = ST_DEC;
					end else begin
						state_nxt = ST_EXP;
					end
				end
			end
			ST_EXP: begin
				if (cnt_last) begin
					state_nxt = ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_nxt = ST_DEC;
			end
			ST_ENC, ST_DEC: begin
				if (cnt_last) begin
					state_nxt = out_free ? ST_IDLE : ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready          = 1'b0;
		cnt_step          = 1'b0;
		round_en          = 1'b0;
		out_load          = 1'b0;
		key_ctrl.load     = 1'b0;
		key_ctrl.step     = 1'b0;
		key_ctrl.step_idx = cnt_q;
		key_ctrl.rd_en    = 1'b0;
		key_ctrl.rd_idx   = LAST_IDX;
		unique case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				key_ctrl.load  = s_tvalid;
				key_ctrl.rd_en = s_tvalid && s_tuser && keys_valid;
			end
			ST_EXP: begin
				cnt_step      = 1'b1;
				key_ctrl.step = 1'b1;
			end
			ST_PRIME: begin
				key_ctrl.rd_en = 1'b1;
			end
			ST_ENC: begin
				cnt_step      = 1'b1;
				round_en      = 1'b1;
				key_ctrl.step = 1'b1;
				out_load      = cnt_last && out_free;
			end
			ST_DEC: begin
				cnt_step        = 1'b1;
				round_en        = 1'b1;
				key_ctrl.rd_en  = !cnt_last;
				key_ctrl.rd_idx = LAST_IDX - cnt_q - IDX_W'(1);
				out_load        = cnt_last && out_free;
			end
			ST_OUT: begin
				out_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// shared round unit
	assign round_key = dec_q ? rd_key : step_key;
	assign f_out     = sub_inv((dec_q ? left_q : right_q) ^ round_key);
	assign mixed     = (dec_q ? right_q : left_q) ^ f_out;
	assign left_nxt  = dec_q ? mixed : right_q;
	assign right_nxt = dec_q ? left_q : mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cnt_step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (accept) begin
			left_q  <= s_tdata[BLOCK_W-1:HALF_W];
			right_q <= s_tdata[HALF_W-1:0];
		end else if (round_en) begin
			left_q  <= left_nxt;
			right_q <= right_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q <= s_tuser;
		end
		if (out_load) begin
			m_tdata_q <= (state_q == ST_OUT) ? {left_q, right_q} : {left_nxt, right_nxt};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`FSBC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)
	`FSBC_ASSERT_IMP(a_dec_needs_keys, clk, arst_n, state_q == ST_DEC, keys_valid)
	`FSBC_ASSERT_NXT(a_result_after_last_round, clk, arst_n,
		round_en && cnt_last && out_free, m_tvalid_q)
	`FSBC_ASSERT_IMP(a_no_cfg_while_busy, clk, arst_n,
		state_q == ST_ENC || state_q == ST_DEC || state_q == ST_EXP, !cfg_wen)

endmodule

`default_nettype wire

// File: bench/tb.sv
// testbench for feistel_sbox_block_cipher: stream driver, key loader and result checker
// a scoreboard class predicts each block from an s-box built in gf(2^8); needs fsbc_pkg
`timescale 1ns / 1ps

typedef enum bit {
	OP_ENCRYPT = 1'b0,
	OP_DECRYPT = 1'b1
} cipher_op_t;

class cipher_scoreboard;
	localparam int ROUNDS = 16;
	localparam int MAX_SHOWN = 10;

	logic [7:0]  fwd_tab [256];
	logic [7:0]  inv_tab [256];
	logic [31:0] key;
	logic [31:0] round_keys [ROUNDS];
	logic [63:0] pending_blocks [$];
	int          errors;
	int          checked;
	int          n_enc;
	int          n_dec;

	function new();
		logic [7:0] b;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			b = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(8'(x), 8'(y)) == 8'h01)
					b = 8'(y);
			end
			s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
			fwd_tab[x] = s;
			inv_tab[s] = 8'(x);
		end
		key = 32'h0;
		errors = 0;
		checked = 0;
		n_enc = 0;
		n_dec = 0;
	endfunction

	function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0])
				p = p ^ a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	function logic [31:0] sub_word(logic [31:0] w, bit inverse);
		if (inverse)
			return {inv_tab[w[31:24]], inv_tab[w[23:16]], inv_tab[w[15:8]], inv_tab[w[7:0]]};
		return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
	endfunction

	function void set_key(logic [31:0] k);
		key = k;
	endfunction

	// full key schedule from the current key, then sixteen rounds
	function logic [63:0] cipher_block(cipher_op_t op, logic [63:0] blk);
		logic [31:0] k;
		logic [31:0] lh;
		logic [31:0] rh;
		logic [31:0] t;
		int          sh;
		k = key;
		for (int r = 1; r <= ROUNDS; r++) begin
			k = sub_word(k, 1'b0);
			sh = r % 32;
			if (sh != 0)
				k = (k << sh) | (k >> (32 - sh));
			round_keys[r - 1] = k;
		end
		lh = blk[63:32];
		rh = blk[31:0];
		if (op == OP_ENCRYPT) begin
			for (int r = 0; r < ROUNDS; r++) begin
				t = rh;
				rh = lh ^ sub_word(rh ^ round_keys[r], 1'b1);
				lh = t;
			end
		end else begin
			for (int r = ROUNDS - 1; r >= 0; r--) begin
				t = lh;
				lh = rh ^ sub_word(lh ^ round_keys[r], 1'b1);
				rh = t;
			end
		end
		return {lh, rh};
	endfunction

	function logic [63:0] note_block(cipher_op_t op, logic [63:0] blk);
		logic [63:0] res;
		res = cipher_block(op, blk);
		pending_blocks.push_back(res);
		if (op == OP_ENCRYPT)
			n_enc++;
		else
			n_dec++;
		return res;
	endfunction

	function void check_block(logic [63:0] got);
		logic [63:0] want;
		if (pending_blocks.size() == 0) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("tb: result %h arrived with no block pending", got);
			return;
		end
		want = pending_blocks.pop_front();
		checked++;
		if (got !== want) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("tb: result_block mismatch on item %0d: expected %h, got %h",
					checked, want, got);
		end
	endfunction
endclass

module tb;
	localparam int LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 534;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [fsbc_pkg::HALF_W-1:0]     cfg_wdata = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [fsbc_pkg::BLOCK_W-1:0]    s_tdata = '0;   // data_block
	logic                            s_tuser = 1'b0; // func
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [fsbc_pkg::BLOCK_W-1:0]    m_tdata;        // result_block

	cipher_scoreboard sb;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int unsigned cycles = 0;
	int          key_loads = 0;
	int          roundtrips = 0;
	logic [63:0] last_cipher = '0;

	feistel_sbox_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// result side: check on handshake, then pick next ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				sb.check_block(m_tdata);
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic push(cipher_op_t op, logic [63:0] blk);
		logic [63:0] res;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= blk;
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		res = sb.note_block(op, blk);
		if (op == OP_ENCRYPT)
			last_cipher = res;
	endtask

	// stop sending and wait until every block is back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(logic [31:0] k);
		cfg_wen <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_key(k);
		key_loads++;
	endtask

	function automatic logic [63:0] pick_block();
		logic [63:0] one;
		one = 64'h1 << $urandom_range(63);
		case ($urandom_range(15))
			0: return 64'h0;
			1: return '1;
			2: return one;
			3: return ~one;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick_key();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		cipher_op_t  op;
		logic [63:0] blk;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: key 0, decrypt before any encrypt
		write_key(32'h0);
		push(OP_DECRYPT, 64'h0);
		push(OP_ENCRYPT, 64'h0);
		push(OP_ENCRYPT, '1);
		push(OP_ENCRYPT, 64'h8000_0000_0000_0001);
		push(OP_ENCRYPT, 64'h0123_4567_89ab_cdef);
		push(OP_DECRYPT, last_cipher);
		push(OP_DECRYPT, '1);
		settle();

		// new key while the store holds keys of the old one: decrypt must use the new key
		write_key(32'hffff_ffff);
		push(OP_DECRYPT, last_cipher);
		push(OP_ENCRYPT, 64'hffff_ffff_0000_0000);
		push(OP_ENCRYPT, 64'h0000_0000_ffff_ffff);
		push(OP_DECRYPT, last_cipher);
		push(OP_ENCRYPT, 64'h0);
		settle();

		write_key(32'h2b7e_1516);
		push(OP_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa);
		push(OP_ENCRYPT, 64'h5555_5555_5555_5555);
		push(OP_DECRYPT, last_cipher);
		push(OP_DECRYPT, 64'h0);
		push(OP_ENCRYPT, '1);
		settle();

		write_key(32'h8000_0001);
		push(OP_ENCRYPT, 64'h1);
		push(OP_DECRYPT, 64'h8000_0000_0000_0000);
		settle();

		// random phases: the first two idle source and sink by different amounts, the last does not idle
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct = 34;
					snk_idle_pct = 64;
				end
				1: begin
					src_idle_pct = 64;
					snk_idle_pct = 34;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			settle();
			write_key(pick_key());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(79) == 0) begin
					settle();
					write_key(pick_key());
				end else if ($urandom_range(99) == 0) begin
					settle();
				end
				op = cipher_op_t'($urandom_range(1));
				if (op == OP_DECRYPT && $urandom_range(2) == 0) begin
					blk = last_cipher;
					roundtrips++;
				end else begin
					blk = pick_block();
				end
				push(op, blk);
			end
		end

		snk_idle_pct = 0;
		settle();

		$display("tb: %0d blocks checked (%0d encrypt, %0d decrypt) over %0d key loads",
			sb.checked, sb.n_enc, sb.n_dec, key_loads);
		$display("tb: %0d earlier ciphertexts fed back for decrypt, %0d mismatches",
			roundtrips, sb.errors);
		if (sb.errors == 0 && sb.pending_blocks.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
